>>> rtl/sprite_rle_row_decoder_top_macros.svh
// Assertion helpers used by the checker file.
// Both forms expect clk and rst_n to be visible where they are used.
`ifndef SPRITE_RLE_ROW_DECODER_TOP_MACROS_SVH
`define SPRITE_RLE_ROW_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SRRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srrd assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SRRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srrd assertion failed");

`endif

>>> rtl/srrd_pkg.sv
package srrd_pkg;

  localparam int SRRD_QUEUE_DEPTH = 4;

  localparam int SRRD_CFG_IDX_W  = 2;
  localparam int SRRD_CFG_DATA_W = 16;

  localparam logic [SRRD_CFG_IDX_W-1:0] SRRD_CFG_COMPACT = 2'd0;
  localparam logic [SRRD_CFG_IDX_W-1:0] SRRD_CFG_WIDTH   = 2'd1;

  localparam logic        SRRD_COMPACT_RESET = 1'b1;
  localparam logic [15:0] SRRD_WIDTH_RESET   = 16'd32;

  // Header codes that announce a block of literal bytes.
  localparam logic [7:0] SRRD_LIT_TYPE = 8'hFF;
  localparam logic [2:0] SRRD_LIT_CODE = 3'd7;

  // One unit of work handed from the parser to the row counter.
  typedef struct packed {
    logic [7:0] value;
    logic [8:0] count;    // run length, literal block length, or 1
    logic       literal;
    logic       add;      // add count to the row pixel total
    logic       check;    // compare the total against the row width
    logic       emit;     // produces a result beat
  } srrd_job_t;

endpackage

>>> rtl/srrd_front.sv
module srrd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  input  logic              compact,
  output logic              job_valid,
  output srrd_pkg::srrd_job_t job
);
  import srrd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] pending_r, pending_nxt;
  logic [8:0] left_r, left_nxt;
  logic [8:0] left_dec;
  logic [8:0] len_two;
  logic [8:0] len_compact;
  logic [2:0] code;

  assign left_dec    = (left_r != 9'd0) ? left_r - 9'd1 : 9'd0;
  assign len_two     = {1'b0, byte_in} + 9'd1;
  assign len_compact = {4'd0, byte_in[4:0]} + 9'd1;
  assign code        = byte_in[7:5];

  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    left_nxt    = left_r;
    job_valid   = 1'b0;
    job.value   = byte_in;
    job.count   = 9'd1;
    job.literal = 1'b0;
    job.add     = 1'b0;
    job.check   = 1'b0;
    job.emit    = 1'b0;
    unique case (phase_r)
      PH_LITERAL: begin
        job_valid   = 1'b1;
        job.literal = 1'b1;
        job.emit    = 1'b1;
        job.check   = (left_dec == 9'd0);
        left_nxt    = left_dec;
        phase_nxt   = (left_dec == 9'd0) ? PH_HEADER : PH_LITERAL;
      end
      PH_LENGTH: begin
        job_valid = 1'b1;
        job.value = pending_r;
        job.count = len_two;
        job.add   = 1'b1;
        if (pending_r == SRRD_LIT_TYPE) begin
          left_nxt  = len_two;
          phase_nxt = PH_LITERAL;
        end else begin
          job.check = 1'b1;
          job.emit  = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        // The unused phase code is read as a header byte.
        if (compact) begin
          job_valid = 1'b1;
          job.value = {5'd0, code};
          job.count = len_compact;
          job.add   = 1'b1;
          if (code == SRRD_LIT_CODE) begin
            left_nxt  = len_compact;
            phase_nxt = PH_LITERAL;
          end else begin
            job.check = 1'b1;
            job.emit  = 1'b1;
            phase_nxt = PH_HEADER;
          end
        end else begin
          pending_nxt = byte_in;
          phase_nxt   = PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pending_r <= 8'd0;
      left_r    <= 9'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

>>> rtl/srrd_queue.sv
module srrd_queue #(
  parameter int Depth = srrd_pkg::SRRD_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  srrd_pkg::srrd_job_t wr_job,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output srrd_pkg::srrd_job_t rd_job
);
  import srrd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  srrd_job_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign full     = (cnt_r == FullCnt);
  assign rd_valid = (cnt_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> rtl/srrd_back.sv
module srrd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       row_width,
  input  logic              job_valid,
  input  srrd_pkg::srrd_job_t job,
  output logic              job_take,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        pixel_value,
  output logic [8:0]        run_count,
  output logic              from_literal,
  output logic              end_of_row
);
  import srrd_pkg::*;

  logic [16:0] pix_r, pix_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  value_r;
  logic [8:0]  count_r;
  logic        literal_r;
  logic        eor_r;
  logic [16:0] sum;
  logic        eor;
  logic        pop_ok;

  assign pop_ok   = pop && valid_r;
  // Jobs without a result beat never wait on the output register.
  assign job_take = job_valid && (!job.emit || !valid_r || pop_ok);
  assign sum      = job.add ? pix_r + {8'd0, job.count} : pix_r;
  assign eor      = job.check && (sum >= {1'b0, row_width});

  always_comb begin
    pix_nxt   = pix_r;
    valid_nxt = valid_r;
    if (pop_ok) begin
      valid_nxt = 1'b0;
    end
    if (job_take) begin
      pix_nxt = eor ? 17'd0 : sum;
      if (job.emit) begin
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r   <= 17'd0;
      valid_r <= 1'b0;
    end else begin
      pix_r   <= pix_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job.emit) begin
      value_r   <= job.value;
      count_r   <= job.literal ? 9'd1 : job.count;
      literal_r <= job.literal;
      eor_r     <= eor;
    end
  end

  assign empty        = !valid_r;
  assign pixel_value  = value_r;
  assign run_count    = count_r;
  assign from_literal = literal_r;
  assign end_of_row   = eor_r;

endmodule

>>> rtl/sprite_rle_row_decoder_top.sv
// Run-length sprite row decoder. Bytes of a coded row enter through push/full at up to one
// beat per clock, and results (value, count, literal flag, end of row) leave through
// empty/pop at up to one beat per clock. A parser classifies each byte and feeds a queue of
// QueueDepth entries; a row counter drains that queue into a single output register, so a
// result passes through the queue and then the output register; full rises only once the
// queue has filled behind a stalled output. Literal-block headers and the type byte of a
// two-byte header produce no result. The registers compact_headers (index 0) and row_width
// (index 1) are written through cfg_valid/cfg_ready, which is always ready; write them only
// while the block is drained.
module sprite_rle_row_decoder_top #(
  parameter int QueueDepth = srrd_pkg::SRRD_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          in_byte_in,
  output logic                                empty,
  input  logic                                pop,
  output logic [7:0]                          out_pixel_value,
  output logic [8:0]                          out_run_count,
  output logic                                out_from_literal,
  output logic                                out_end_of_row,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srrd_pkg::SRRD_CFG_IDX_W-1:0] cfg_index,
  input  logic [srrd_pkg::SRRD_CFG_DATA_W-1:0] cfg_data
);
  import srrd_pkg::*;

  logic        compact_r;
  logic [15:0] width_r;
  logic        accept;
  logic        fjob_valid;
  srrd_job_t   fjob;
  logic        qvalid;
  srrd_job_t   qjob;
  logic        qtake;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compact_r <= SRRD_COMPACT_RESET;
      width_r   <= SRRD_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to an unmapped index are dropped.
      unique case (cfg_index)
        SRRD_CFG_COMPACT: begin
          compact_r <= cfg_data[0];
        end
        SRRD_CFG_WIDTH: begin
          width_r <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  srrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .byte_in  (in_byte_in),
    .compact  (compact_r),
    .job_valid(fjob_valid),
    .job      (fjob)
  );

  srrd_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && fjob_valid),
    .wr_job  (fjob),
    .full    (full),
    .rd_en   (qtake),
    .rd_valid(qvalid),
    .rd_job  (qjob)
  );

  srrd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .row_width   (width_r),
    .job_valid   (qvalid),
    .job         (qjob),
    .job_take    (qtake),
    .pop         (pop),
    .empty       (empty),
    .pixel_value (out_pixel_value),
    .run_count   (out_run_count),
    .from_literal(out_from_literal),
    .end_of_row  (out_end_of_row)
  );

endmodule

>>> rtl/srrd_checker.sv
`include "sprite_rle_row_decoder_top_macros.svh"

module srrd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                full,
  input logic                                empty,
  input logic                                pop,
  input logic [7:0]                          out_pixel_value,
  input logic [8:0]                          out_run_count,
  input logic                                out_from_literal,
  input logic                                out_end_of_row
);

  // A literal beat always stands for exactly one pixel.
  `SRRD_ASSERT_NOW(a_literal_single, !empty && out_from_literal, out_run_count == 9'd1)

  // No beat ever carries an empty run.
  `SRRD_ASSERT_NOW(a_count_nonzero, !empty, out_run_count != 9'd0)

  // The input only backs up behind a result that is waiting to be taken.
  `SRRD_ASSERT_NOW(a_full_has_beat, full, !empty)

  // A beat that is not taken stays on the ports unchanged.
  `SRRD_ASSERT_NEXT(a_stall_holds, !empty && !pop,
    !empty && $stable(out_pixel_value) && $stable(out_run_count) &&
    $stable(out_from_literal) && $stable(out_end_of_row))

endmodule

bind sprite_rle_row_decoder_top srrd_checker u_srrd_checker (.*);
